FILE: src/tvc_pkg.sv
package tvc_pkg;

	typedef enum logic [1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_STORE  = 2'd1,
		MODE_INVAL  = 2'd2,
		MODE_FLUSH  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACT_ALLOW = 2'd0,
		ACT_BLOCK = 2'd1,
		ACT_WARN  = 2'd2,
		ACT_OTHER = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	localparam logic [1:0] CFG_ALLOW_TTL = 2'd0;
	localparam logic [1:0] CFG_BLOCK_TTL = 2'd1;
	localparam logic [1:0] CFG_WARN_TTL  = 2'd2;

	localparam logic [15:0] ALLOW_TTL_RESET = 16'(24 * 60);
	localparam logic [15:0] BLOCK_TTL_RESET = 16'(7 * 24 * 60);
	localparam logic [15:0] WARN_TTL_RESET  = 16'(4 * 60);

	localparam logic [31:0] MS_PER_MINUTE = 32'd60000;
	localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] key_word0;
		logic [63:0] key_word1;
		logic [63:0] key_word2;
		logic [63:0] key_word3;
		logic [1:0]  verdict_action;
		logic [7:0]  verdict_severity;
		logic [31:0] now_ms;
		logic        clock_trusted;
	} in_item_t;

	typedef struct packed {
		logic        hit;
		logic [1:0]  hit_action;
		logic [7:0]  hit_severity;
		logic [15:0] hit_ttl_minutes;
	} out_item_t;

	// one memory word per cache slot
	typedef struct packed {
		logic [255:0] key;
		logic [1:0]   action;
		logic [7:0]   severity;
		logic [15:0]  ttl;
		logic [31:0]  time_ms;
	} entry_t;

	// per-slot verdict of the scan pipeline
	typedef struct packed {
		logic        match;
		logic        free;
		logic        expired;
		logic [31:0] time_ms;
		logic [1:0]  action;
		logic [7:0]  severity;
		logic [15:0] ttl;
	} eval_t;

endpackage

FILE: src/ttl_verdict_cache.sv
// ttl verdict cache: fully associative, keyed by a 256-bit hash, with a lifetime per entry
//
// input channel (in_valid / in_stall / in_data) carries one operation per transaction:
// lookup, store, invalidate or flush. every operation returns exactly one result
// transaction on the output channel (out_valid / out_stall / out_data); only a lookup
// can report a hit. one operation is in progress at a time: in_stall is high from
// acceptance until the result has been loaded into the output register.
// lookup and invalidate walk the slots through the entry memory, one read a cycle,
// stopping at the first valid match; store walks until the first free slot or over all
// slots to find the oldest one; flush needs no walk. each slot read passes the single read
// port of the entry memory and then the compare pipeline (stages s2 and s3) behind it.
// the input reopens the cycle after the result is loaded into the output register.
// the ttl registers are written through cfg_we / cfg_index / cfg_data; the user writes
// them only while idle, and the block itself does not enforce this.
// reset empties the cache at once (valid bits are flip-flops) and loads the default ttls.
// a stalled result sits in the output register; the next operation may already be
// accepted and runs until its own result is due, then waits for the register to drain.
module ttl_verdict_cache #(
	parameter int ENTRIES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tvc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output tvc_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	tvc_pkg::state_t    state_q, state_d;
	tvc_pkg::in_item_t  in_q;
	tvc_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic [15:0] allow_ttl_q, block_ttl_q, warn_ttl_q;
	logic [ENTRIES-1:0] valid_q;

	logic [CW-1:0] rd_cnt_q;
	logic          rd_en;
	logic          v_s1;
	logic [IW-1:0] idx_s1;

	logic           e_v;
	logic [IW-1:0]  e_idx;
	tvc_pkg::eval_t e_res;

	logic           dec_v, stop, end_scan, fin_go, accept;

	// scan outcome
	logic          found_q, expired_q;
	logic [IW-1:0] hit_idx_q;
	logic [1:0]    res_action_q;
	logic [7:0]    res_severity_q;
	logic [15:0]   res_ttl_q;
	logic          have_free_q;
	logic [IW-1:0] free_idx_q, best_idx_q;
	logic [31:0]   best_time_q;

	logic [IW-1:0]   victim_idx;
	logic [15:0]     store_ttl;
	tvc_pkg::entry_t wr_entry;
	tvc_pkg::entry_t rd_entry;
	logic            ram_we;

	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_ttl_q <= tvc_pkg::ALLOW_TTL_RESET;
			block_ttl_q <= tvc_pkg::BLOCK_TTL_RESET;
			warn_ttl_q  <= tvc_pkg::WARN_TTL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tvc_pkg::CFG_ALLOW_TTL: allow_ttl_q <= cfg_data;
				tvc_pkg::CFG_BLOCK_TTL: block_ttl_q <= cfg_data;
				tvc_pkg::CFG_WARN_TTL:  warn_ttl_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (in_q.verdict_action)
			tvc_pkg::ACT_ALLOW: store_ttl = allow_ttl_q;
			tvc_pkg::ACT_BLOCK: store_ttl = block_ttl_q;
			tvc_pkg::ACT_WARN:  store_ttl = warn_ttl_q;
			default:            store_ttl = 16'd0;
		endcase
	end

	assign dec_v = (state_q == tvc_pkg::ST_SCAN) && e_v;

	always_comb begin
		case (in_q.mode)
			tvc_pkg::MODE_LOOKUP, tvc_pkg::MODE_INVAL: stop = dec_v && e_res.match;
			tvc_pkg::MODE_STORE:                       stop = dec_v && e_res.free;
			default:                                   stop = 1'b0;
		endcase
	end

	assign end_scan = stop || (dec_v && (e_idx == LAST_IDX));
	assign rd_en    = (state_q == tvc_pkg::ST_SCAN) && (rd_cnt_q < CW'(ENTRIES)) && !stop;
	assign fin_go   = (state_q == tvc_pkg::ST_FINISH) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			tvc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = (in_data.mode == tvc_pkg::MODE_FLUSH) ?
						tvc_pkg::ST_FINISH : tvc_pkg::ST_SCAN;
				end
			end
			tvc_pkg::ST_SCAN: begin
				if (end_scan) begin
					state_d = tvc_pkg::ST_FINISH;
				end
			end
			tvc_pkg::ST_FINISH: begin
				if (fin_go) begin
					state_d = tvc_pkg::ST_IDLE;
				end
			end
			default: state_d = tvc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			if (accept) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[IW-1:0];
	end

	tvc_entry_ram #(
		.DEPTH (ENTRIES),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (victim_idx),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (rd_entry)
	);

	tvc_eval #(
		.IW (IW)
	) u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.kill     (state_q != tvc_pkg::ST_SCAN),
		.v_s1     (v_s1),
		.idx_s1   (idx_s1),
		.valid_s1 (valid_q[idx_s1]),
		.ent_s1   (rd_entry),
		.key      ({in_q.key_word0, in_q.key_word1, in_q.key_word2, in_q.key_word3}),
		.now_ms   (in_q.now_ms),
		.trusted  (in_q.clock_trusted),
		.v_s3     (e_v),
		.idx_s3   (e_idx),
		.res_s3   (e_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
			best_time_q <= tvc_pkg::TIME_MAX;
			best_idx_q  <= '0;
		end else if (accept) begin
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
			best_time_q <= tvc_pkg::TIME_MAX;
			best_idx_q  <= '0;
		end else if (dec_v) begin
			if (stop && in_q.mode != tvc_pkg::MODE_STORE) begin
				found_q <= 1'b1;
			end
			if (stop && in_q.mode == tvc_pkg::MODE_STORE) begin
				have_free_q <= 1'b1;
			end
			// oldest by raw timestamp, lowest index wins ties
			if (!e_res.free && e_res.time_ms < best_time_q) begin
				best_time_q <= e_res.time_ms;
				best_idx_q  <= e_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stop) begin
			hit_idx_q      <= e_idx;
			free_idx_q     <= e_idx;
			expired_q      <= e_res.expired;
			res_action_q   <= e_res.action;
			res_severity_q <= e_res.severity;
			res_ttl_q      <= e_res.ttl;
		end
	end

	assign victim_idx = have_free_q ? free_idx_q : best_idx_q;
	assign ram_we     = fin_go && (in_q.mode == tvc_pkg::MODE_STORE);

	always_comb begin
		wr_entry.key      = {in_q.key_word0, in_q.key_word1, in_q.key_word2, in_q.key_word3};
		wr_entry.action   = in_q.verdict_action;
		wr_entry.severity = in_q.verdict_severity;
		wr_entry.ttl      = store_ttl;
		wr_entry.time_ms  = in_q.now_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (fin_go) begin
			case (in_q.mode)
				tvc_pkg::MODE_LOOKUP: begin
					if (found_q && expired_q) begin
						valid_q[hit_idx_q] <= 1'b0;
					end
				end
				tvc_pkg::MODE_STORE: valid_q[victim_idx] <= 1'b1;
				tvc_pkg::MODE_INVAL: begin
					if (found_q) begin
						valid_q[hit_idx_q] <= 1'b0;
					end
				end
				default: valid_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			if (in_q.mode == tvc_pkg::MODE_LOOKUP && found_q && !expired_q) begin
				out_q.hit             <= 1'b1;
				out_q.hit_action      <= res_action_q;
				out_q.hit_severity    <= res_severity_q;
				out_q.hit_ttl_minutes <= res_ttl_q;
			end else begin
				out_q <= '0;
			end
		end
	end

`ifndef SYNTH
	// one operation in flight: acceptance closes the input until the result is loaded
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input accepted while an operation is in progress");

	// a result appears only from the finish step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == tvc_pkg::ST_FINISH))
		else $error("result without a finished operation");

	// a store leaves its victim slot valid
	a_store_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(victim_idx)])
		else $error("stored slot not marked valid");

	// only a lookup can report a hit
	a_hit_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && in_q.mode != tvc_pkg::MODE_LOOKUP) |=> !out_q.hit)
		else $error("hit reported for a non-lookup operation");

	// the scan stays within the slots and stops after the last one
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_v && e_idx == LAST_IDX) |=> state_q == tvc_pkg::ST_FINISH)
		else $error("scan ran past the last slot");
`endif

endmodule

FILE: src/tvc_entry_ram.sv
module tvc_entry_ram #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  tvc_pkg::entry_t   wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output tvc_pkg::entry_t   rdata
);

	tvc_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/tvc_eval.sv
module tvc_eval #(
	parameter int IW = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            kill,
	input  logic            v_s1,
	input  logic [IW-1:0]   idx_s1,
	input  logic            valid_s1,
	input  tvc_pkg::entry_t ent_s1,
	input  logic [255:0]    key,
	input  logic [31:0]     now_ms,
	input  logic            trusted,
	output logic            v_s3,
	output logic [IW-1:0]   idx_s3,
	output tvc_pkg::eval_t  res_s3
);

	logic          v_s2;
	logic [IW-1:0] idx_s2;
	logic          match_s2;
	logic          free_s2;
	logic [31:0]   diff_s2;
	logic [31:0]   thr_s2;
	logic [31:0]   time_s2;
	logic [1:0]    action_s2;
	logic [7:0]    severity_s2;
	logic [15:0]   ttl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && !kill;
			v_s3 <= v_s2 && !kill;
		end
	end

	// key compare, elapsed time and expiry threshold in ms
	always_ff @(posedge clk) begin
		idx_s2      <= idx_s1;
		match_s2    <= valid_s1 && (ent_s1.key == key);
		free_s2     <= !valid_s1;
		diff_s2     <= now_ms - ent_s1.time_ms;
		thr_s2      <= 32'(ent_s1.ttl) * tvc_pkg::MS_PER_MINUTE;
		time_s2     <= ent_s1.time_ms;
		action_s2   <= ent_s1.action;
		severity_s2 <= ent_s1.severity;
		ttl_s2      <= ent_s1.ttl;
	end

	// whole minutes reach ttl exactly when the ms difference reaches ttl * 60000
	always_ff @(posedge clk) begin
		idx_s3          <= idx_s2;
		res_s3.match    <= match_s2;
		res_s3.free     <= free_s2;
		res_s3.expired  <= !trusted || (diff_s2 >= thr_s2);
		res_s3.time_ms  <= time_s2;
		res_s3.action   <= action_s2;
		res_s3.severity <= severity_s2;
		res_s3.ttl      <= ttl_s2;
	end

endmodule

FILE: test/ttl_verdict_cache_test.sv
`timescale 1ns / 100ps

module ttl_verdict_cache_test;

	localparam int SLOTS = 16;
	localparam int POOL_KEYS = 12;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASE_ITEMS = 90;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	localparam logic [1:0] KEY_ONES = 2'd0;
	localparam logic [1:0] KEY_ZERO = 2'd1;
	localparam logic [1:0] KEY_MIX  = 2'd2;

	localparam tvc_pkg::out_item_t MISS = '0;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_kind_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [1:0]         key_sel;
		logic [1:0]         action;
		logic [7:0]         severity;
		logic [31:0]        now_ms;
		logic               trusted;
		logic               fixed;
		tvc_pkg::out_item_t want;
	} dir_row_t;

	typedef struct packed {
		logic               fixed;
		tvc_pkg::out_item_t value;
	} fixed_answer_t;

	// directed rows; answers typed in only where they are obvious
	localparam dir_row_t DIR_TABLE [23] = '{
		'{tvc_pkg::MODE_LOOKUP, KEY_ONES, tvc_pkg::ACT_ALLOW,
			8'h00, 32'd0,         1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_STORE,  KEY_ONES, tvc_pkg::ACT_ALLOW,
			8'hFF, 32'd0,         1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_LOOKUP, KEY_ONES, tvc_pkg::ACT_ALLOW,
			8'h00, 32'd0,         1'b1, 1'b1,
			'{1'b1, tvc_pkg::ACT_ALLOW, 8'hFF, 16'd1440}},
		'{tvc_pkg::MODE_LOOKUP, KEY_ONES, tvc_pkg::ACT_ALLOW,
			8'h00, 32'd86399999,  1'b1, 1'b0, MISS},
		'{tvc_pkg::MODE_LOOKUP, KEY_ONES, tvc_pkg::ACT_ALLOW,
			8'h00, 32'd86400000,  1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_LOOKUP, KEY_ONES, tvc_pkg::ACT_ALLOW,
			8'h00, 32'd0,         1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_STORE,  KEY_ZERO, tvc_pkg::ACT_BLOCK,
			8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_LOOKUP, KEY_ZERO, tvc_pkg::ACT_ALLOW,
			8'h00, 32'd604799998, 1'b1, 1'b0, MISS},
		'{tvc_pkg::MODE_LOOKUP, KEY_ZERO, tvc_pkg::ACT_ALLOW,
			8'h00, 32'd604799998, 1'b0, 1'b1, MISS},
		'{tvc_pkg::MODE_STORE,  KEY_MIX,  tvc_pkg::ACT_OTHER,
			8'h5A, 32'd1000,      1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_LOOKUP, KEY_MIX,  tvc_pkg::ACT_ALLOW,
			8'h00, 32'd1000,      1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_STORE,  KEY_MIX,  tvc_pkg::ACT_WARN,
			8'h81, 32'd5000,      1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_STORE,  KEY_MIX,  tvc_pkg::ACT_WARN,
			8'h7E, 32'd6000,      1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_LOOKUP, KEY_MIX,  tvc_pkg::ACT_ALLOW,
			8'h00, 32'd7000,      1'b1, 1'b0, MISS},
		'{tvc_pkg::MODE_INVAL,  KEY_MIX,  tvc_pkg::ACT_ALLOW,
			8'h00, 32'd7000,      1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_LOOKUP, KEY_MIX,  tvc_pkg::ACT_ALLOW,
			8'h00, 32'd7000,      1'b1, 1'b0, MISS},
		'{tvc_pkg::MODE_FLUSH,  KEY_ONES, tvc_pkg::ACT_OTHER,
			8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1, MISS},
		'{tvc_pkg::MODE_LOOKUP, KEY_MIX,  tvc_pkg::ACT_ALLOW,
			8'h00, 32'd7000,      1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_STORE,  KEY_ONES, tvc_pkg::ACT_OTHER,
			8'h33, 32'd100,       1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_STORE,  KEY_ONES, tvc_pkg::ACT_ALLOW,
			8'h44, 32'd200,       1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_LOOKUP, KEY_ONES, tvc_pkg::ACT_ALLOW,
			8'h00, 32'd300,       1'b1, 1'b1, MISS},
		'{tvc_pkg::MODE_LOOKUP, KEY_ONES, tvc_pkg::ACT_ALLOW,
			8'h00, 32'd300,       1'b1, 1'b0, MISS},
		'{tvc_pkg::MODE_INVAL,  KEY_ZERO, tvc_pkg::ACT_ALLOW,
			8'h00, 32'd300,       1'b1, 1'b1, MISS}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	tvc_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	tvc_pkg::out_item_t out_data;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	ttl_verdict_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// predictor copy of the cache
	logic         slot_valid [SLOTS];
	logic [255:0] slot_key   [SLOTS];
	logic [1:0]   slot_action[SLOTS];
	logic [7:0]   slot_sev   [SLOTS];
	logic [15:0]  slot_ttl   [SLOTS];
	logic [31:0]  slot_time  [SLOTS];
	logic [15:0]  ttl_allow = tvc_pkg::ALLOW_TTL_RESET;
	logic [15:0]  ttl_block = tvc_pkg::BLOCK_TTL_RESET;
	logic [15:0]  ttl_warn  = tvc_pkg::WARN_TTL_RESET;

	tvc_pkg::in_item_t  stim_q[$];
	fixed_answer_t      fixed_answer_q[$];
	tvc_pkg::out_item_t expected_verdicts[$];
	int                 items_open = 0;
	int                 phase_items = 0;
	int                 errors = 0;

	logic [255:0] key_pool [POOL_KEYS];
	logic [31:0]  clock_ms = '0;

	bit idle_on = 1'b1;
	bit quiet = 1'b0;
	int hold_asks = 0;

	initial begin
		for (int i = 0; i < SLOTS; i++)
			slot_valid[i] = 1'b0;
	end

	function automatic logic [15:0] lifetime_of(logic [1:0] a);
		case (tvc_pkg::action_t'(a))
			tvc_pkg::ACT_ALLOW: return ttl_allow;
			tvc_pkg::ACT_BLOCK: return ttl_block;
			tvc_pkg::ACT_WARN:  return ttl_warn;
			default:            return 16'd0;
		endcase
	endfunction

	function automatic tvc_pkg::out_item_t predict_verdict(tvc_pkg::in_item_t it);
		tvc_pkg::out_item_t r;
		logic [255:0]       k;
		logic [31:0]        age_min;
		logic [31:0]        oldest;
		int                 victim;
		int                 best;
		bit                 done;
		r = '0;
		k = {it.key_word3, it.key_word2, it.key_word1, it.key_word0};
		done = 1'b0;
		case (tvc_pkg::mode_t'(it.mode))
			tvc_pkg::MODE_LOOKUP: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!done && slot_valid[i] && slot_key[i] == k) begin
						done = 1'b1;
						age_min = (it.now_ms - slot_time[i]) / tvc_pkg::MS_PER_MINUTE;
						if (!it.clock_trusted || age_min >= {16'd0, slot_ttl[i]}) begin
							slot_valid[i] = 1'b0;
						end else begin
							r.hit = 1'b1;
							r.hit_action = slot_action[i];
							r.hit_severity = slot_sev[i];
							r.hit_ttl_minutes = slot_ttl[i];
						end
					end
				end
			end
			tvc_pkg::MODE_STORE: begin
				victim = -1;
				best = 0;
				oldest = tvc_pkg::TIME_MAX;
				for (int i = 0; i < SLOTS; i++) begin
					if (victim < 0 && !slot_valid[i])
						victim = i;
					if (slot_time[i] < oldest) begin
						oldest = slot_time[i];
						best = i;
					end
				end
				if (victim < 0)
					victim = best;
				slot_key[victim] = k;
				slot_action[victim] = it.verdict_action;
				slot_sev[victim] = it.verdict_severity;
				slot_ttl[victim] = lifetime_of(it.verdict_action);
				slot_time[victim] = it.now_ms;
				slot_valid[victim] = 1'b1;
			end
			tvc_pkg::MODE_INVAL: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!done && slot_valid[i] && slot_key[i] == k) begin
						done = 1'b1;
						slot_valid[i] = 1'b0;
					end
				end
			end
			default: begin
				for (int i = 0; i < SLOTS; i++)
					slot_valid[i] = 1'b0;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		errors++;
	endtask

	// sender: bursts of transactions with random gaps
	int burst_left = 0;
	int gap_left = 0;

	task automatic offer_next();
		if (stim_q.size() == 0 || gap_left > 0) begin
			in_valid <= 1'b0;
		end else begin
			in_data <= stim_q.pop_front();
			in_valid <= 1'b1;
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				burst_left = idle_on ? $urandom_range(1, 10) : 64;
				if (!idle_on)
					gap_left = 0;
				else if ($urandom_range(0, 3) == 0)
					gap_left = $urandom_range(6, 30);
				else
					gap_left = $urandom_range(0, 3);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				offer_next();
			end else if (!in_valid) begin
				if (gap_left > 0)
					gap_left--;
				else
					offer_next();
			end
		end
	end

	// receiver: stall pattern of its own, plus a long hold-off on request
	int          hold_seen = 0;
	int          hold_left = 0;
	int          pattern_left = 0;
	int          rx_cycle = 0;
	stall_kind_t stall_kind = STALL_NONE;

	always @(posedge clk) begin
		rx_cycle++;
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else begin
			if (pattern_left == 0) begin
				stall_kind = stall_kind_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(20, 200);
			end
			pattern_left--;
			case (stall_kind)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= rx_cycle[2];
			endcase
		end
	end

	// result check first, so a new expectation never pairs with an older result
	always @(posedge clk) begin
		tvc_pkg::out_item_t want;
		tvc_pkg::out_item_t predicted;
		fixed_answer_t      answer;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch("result with no pending operation", 64'(out_data), 64'd0);
				end else begin
					want = expected_verdicts.pop_front();
					items_open--;
					if (out_data.hit !== want.hit)
						report_mismatch("hit", 64'(out_data.hit), 64'(want.hit));
					if (out_data.hit_action !== want.hit_action)
						report_mismatch("hit_action", 64'(out_data.hit_action),
							64'(want.hit_action));
					if (out_data.hit_severity !== want.hit_severity)
						report_mismatch("hit_severity", 64'(out_data.hit_severity),
							64'(want.hit_severity));
					if (out_data.hit_ttl_minutes !== want.hit_ttl_minutes)
						report_mismatch("hit_ttl_minutes", 64'(out_data.hit_ttl_minutes),
							64'(want.hit_ttl_minutes));
				end
			end
			if (in_valid && !in_stall) begin
				predicted = predict_verdict(in_data);
				answer = fixed_answer_q.pop_front();
				expected_verdicts.push_back(answer.fixed ? answer.value : predicted);
			end
		end
	end

	function automatic logic [255:0] fresh_key();
		logic [255:0] k;
		for (int w = 0; w < 8; w++)
			k[32 * w +: 32] = $urandom;
		return k;
	endfunction

	function automatic logic [255:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_KEYS - 1)];
		return fresh_key();
	endfunction

	function automatic tvc_pkg::in_item_t make_item(logic [1:0] m, logic [255:0] k,
			logic [1:0] a, logic [7:0] sev, logic [31:0] now, logic trusted);
		tvc_pkg::in_item_t it;
		it.mode = m;
		it.key_word0 = k[63:0];
		it.key_word1 = k[127:64];
		it.key_word2 = k[191:128];
		it.key_word3 = k[255:192];
		it.verdict_action = a;
		it.verdict_severity = sev;
		it.now_ms = now;
		it.clock_trusted = trusted;
		return it;
	endfunction

	task automatic queue_op(logic [1:0] m, logic [255:0] k, logic [31:0] now, logic trusted);
		stim_q.push_back(make_item(m, k, 2'($urandom_range(0, 3)),
			8'($urandom_range(0, 255)), now, trusted));
		fixed_answer_q.push_back('0);
		items_open++;
		phase_items++;
	endtask

	task automatic queue_store(logic [255:0] k, logic [1:0] a, logic [31:0] now);
		stim_q.push_back(make_item(tvc_pkg::MODE_STORE, k, a, 8'($urandom_range(0, 255)),
			now, 1'($urandom_range(0, 1))));
		fixed_answer_q.push_back('0);
		items_open++;
		phase_items++;
	endtask

	task automatic advance_clock();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: clock_ms += $urandom_range(0, 20000);
			6, 7:             clock_ms += $urandom_range(1, 4) * tvc_pkg::MS_PER_MINUTE;
			8:                clock_ms += $urandom;
			default:          ;
		endcase
	endtask

	task automatic gen_random(int target);
		logic [255:0] k;
		logic [31:0]  t;
		logic [31:0]  limit_ms;
		logic [1:0]   a;
		int           kind;
		int           r;
		int           scheme;
		for (int i = 0; i < POOL_KEYS; i++) begin
			if (i > 0 && $urandom_range(0, 3) == 0) begin
				// near neighbour: differs from the previous key in one word only
				k = key_pool[i - 1];
				k[64 * $urandom_range(0, 3) +: 64] = {$urandom, $urandom};
				key_pool[i] = k;
			end else begin
				key_pool[i] = fresh_key();
			end
		end
		phase_items = 0;
		while (phase_items < target) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				for (int n = 0; n < 8; n++) begin
					r = $urandom_range(0, 99);
					k = pick_key();
					advance_clock();
					if (r < 45)
						queue_op(tvc_pkg::MODE_LOOKUP, k, clock_ms, $urandom_range(0, 9) != 0);
					else if (r < 78)
						queue_store(k, 2'($urandom_range(0, 3)), clock_ms);
					else if (r < 96)
						queue_op(tvc_pkg::MODE_INVAL, k, $urandom,
							1'($urandom_range(0, 1)));
					else
						queue_op(tvc_pkg::MODE_FLUSH, fresh_key(), $urandom,
							1'($urandom_range(0, 1)));
				end
			end else if (kind < 7) begin
				// fill every slot and push past it to force replacement
				scheme = $urandom_range(0, 3);
				t = $urandom;
				for (int n = $urandom_range(16, 18); n > 0; n--) begin
					case (scheme)
						0: t = tvc_pkg::TIME_MAX;
						1: ;
						2: t = $urandom;
						default: t = clock_ms + $urandom_range(0, 5000);
					endcase
					queue_store(($urandom_range(0, 1) != 0) ? pick_key() : fresh_key(),
						2'($urandom_range(0, 3)), t);
				end
				for (int n = 0; n < 4; n++)
					queue_op(tvc_pkg::MODE_LOOKUP, pick_key(), clock_ms, 1'b1);
			end else begin
				// expiry boundary around store time plus ttl
				k = pick_key();
				a = 2'($urandom_range(0, 3));
				t = $urandom;
				limit_ms = t + 32'(lifetime_of(a)) * tvc_pkg::MS_PER_MINUTE;
				case ($urandom_range(0, 3))
					0: limit_ms -= 32'd1;
					1: ;
					2: limit_ms -= tvc_pkg::MS_PER_MINUTE;
					default: limit_ms += 32'd1;
				endcase
				if ($urandom_range(0, 1) != 0)
					queue_op(tvc_pkg::MODE_FLUSH, fresh_key(), $urandom,
						1'($urandom_range(0, 1)));
				queue_store(k, a, t);
				queue_op(tvc_pkg::MODE_LOOKUP, k, limit_ms, $urandom_range(0, 7) != 0);
				queue_op(tvc_pkg::MODE_LOOKUP, k, limit_ms, 1'b1);
				clock_ms = limit_ms;
			end
		end
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tvc_pkg::CFG_ALLOW_TTL: ttl_allow = value;
			tvc_pkg::CFG_BLOCK_TTL: ttl_block = value;
			tvc_pkg::CFG_WARN_TTL:  ttl_warn = value;
			default:                ;
		endcase
	endtask

	task automatic wait_idle();
		while (items_open != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(logic [15:0] allow_ttl, logic [15:0] block_ttl,
			logic [15:0] warn_ttl, bit idle, bit calm, bit pressure, int target);
		cfg_write(tvc_pkg::CFG_ALLOW_TTL, allow_ttl);
		cfg_write(tvc_pkg::CFG_BLOCK_TTL, block_ttl);
		cfg_write(tvc_pkg::CFG_WARN_TTL, warn_ttl);
		idle_on = idle;
		quiet = calm;
		gen_random(target);
		if (pressure)
			hold_asks++;
		wait_idle();
	endtask

	initial begin
		logic [255:0] k;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TABLE[i]) begin
			case (DIR_TABLE[i].key_sel)
				KEY_ONES: k = '1;
				KEY_ZERO: k = '0;
				default:  k = {64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
					64'hA5A5_5A5A_C3C3_3C3C, 64'h0F0F_F0F0_9669_6996};
			endcase
			stim_q.push_back(make_item(DIR_TABLE[i].mode, k, DIR_TABLE[i].action,
				DIR_TABLE[i].severity, DIR_TABLE[i].now_ms, DIR_TABLE[i].trusted));
			fixed_answer_q.push_back('{DIR_TABLE[i].fixed, DIR_TABLE[i].want});
			items_open++;
		end
		wait_idle();

		// spare register index must leave the ttls untouched
		cfg_write(CFG_SPARE, 16'($urandom_range(0, 65535)));
		run_phase(16'd0, 16'hFFFF, 16'd1, 1'b1, 1'b0, 1'b0, PHASE_ITEMS);
		run_phase(16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)),
			16'($urandom_range(1, 3)), 1'b1, 1'b0, 1'b1, PHASE_ITEMS);
		run_phase(16'($urandom_range(1000, 65535)), 16'd0, 16'hFFFF, 1'b0, 1'b1, 1'b0,
			PHASE_ITEMS);
		run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 2)),
			16'($urandom_range(0, 5)), 1'b1, 1'b0, 1'b0, PHASE_ITEMS);

		if (errors == 0)
			$display("ttl_verdict_cache_test: done, clean");
		else
			$display("ttl_verdict_cache_test: done, errors");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("%0t timeout with %0d transactions outstanding", $realtime, items_open);
		$display("ttl_verdict_cache_test: done, errors");
		$finish;
	end

endmodule
